@@ src/tcw_pkg.sv @@
// shared types and constants for the text console writer
`default_nettype none
package tcw_pkg;

  localparam int MAX_COLS_DEF = 80;
  localparam int MAX_ROWS_DEF = 25;
  localparam int TAB_STEP_DEF = 4;

  localparam int COLS_W   = 7;
  localparam int ROWS_W   = 5;
  localparam int CHAR_W   = 8;
  localparam int IDX_W    = 11;
  localparam int CELL_W   = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 7;

  localparam logic [COLS_W-1:0] COLS_RST   = 7'd80;
  localparam logic [ROWS_W-1:0] ROWS_RST   = 5'd25;
  localparam logic              FOLLOW_RST = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_COLUMNS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FOLLOW  = 2'd2;

  localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
  localparam logic [CHAR_W-1:0] CH_TAB     = 8'd9;
  localparam logic [CHAR_W-1:0] CH_BKSP    = 8'd8;
  localparam logic [CHAR_W-1:0] CH_BLANK   = 8'h20;
  localparam logic [CHAR_W-1:0] ATTR_BYTE  = 8'h0F;

  localparam logic [2:0] OP_READ = 3'd0;
  localparam logic [2:0] OP_NL   = 3'd1;
  localparam logic [2:0] OP_TAB  = 3'd2;
  localparam logic [2:0] OP_BKSP = 3'd3;
  localparam logic [2:0] OP_CHAR = 3'd4;

  localparam int QDEPTH = 2;

  typedef struct packed {
    logic [2:0]        op;
    logic [CHAR_W-1:0] ch;
    logic [IDX_W-1:0]  ridx;
  } tcw_item_t;

  typedef struct packed {
    logic pop;
    logic clr_done;
  } tcw_qctl_t;

endpackage
`default_nettype wire

@@ src/tcw_ram.sv @@
// generic simple dual-port ram with registered read
`default_nettype none
module tcw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2000,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

@@ src/tcw_div.sv @@
// bit-serial remainder unit for newline column alignment
`default_nettype none
module tcw_div #(
  parameter int POS_W = 13
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [POS_W-1:0]          dividend,
  input  wire logic [tcw_pkg::COLS_W-1:0] divisor,
  output logic                           done,
  output logic [tcw_pkg::COLS_W-1:0]     rem
);
  import tcw_pkg::*;

  localparam int CW = $clog2(POS_W + 1);

  logic              busy_r;
  logic              done_r;
  logic [CW-1:0]     cnt_r;
  logic [POS_W-1:0]  dv_r;
  logic [COLS_W-1:0] rem_r;
  logic [COLS_W-1:0] dsr_r;
  logic [COLS_W:0]   trial;
  logic              fit;
  logic [COLS_W-1:0] rem_step;

  assign trial    = {rem_r, dv_r[POS_W-1]};
  assign fit      = trial >= {1'b0, dsr_r};
  assign rem_step = fit ? COLS_W'(trial - {1'b0, dsr_r}) : trial[COLS_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(POS_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dv_r  <= dividend;
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (busy_r) begin
      dv_r  <= dv_r << 1;
      rem_r <= rem_step;
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule
`default_nettype wire

@@ src/tcw_front.sv @@
// input side: accepts beats, classifies characters, queues work for the back end
`default_nettype none
module tcw_front (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic                      in_kind,
  input  wire logic [tcw_pkg::CHAR_W-1:0] in_char_code,
  input  wire logic [tcw_pkg::IDX_W-1:0]  in_read_index,
  input  wire tcw_pkg::tcw_qctl_t        ctl,
  output tcw_pkg::tcw_item_t             q_item,
  output logic                           q_valid
);
  import tcw_pkg::*;

  tcw_item_t   q_mem_r [QDEPTH];
  logic        wp_r;
  logic        rp_r;
  logic [1:0]  cnt_r;
  logic        push;
  tcw_item_t   item;

  always_comb begin
    item.ch   = in_char_code;
    item.ridx = in_read_index;
    if (in_kind) begin
      item.op = OP_READ;
    end else if (in_char_code == CH_NEWLINE) begin
      item.op = OP_NL;
    end else if (in_char_code == CH_TAB) begin
      item.op = OP_TAB;
    end else if (in_char_code == CH_BKSP) begin
      item.op = OP_BKSP;
    end else begin
      item.op = OP_CHAR;
    end
  end

  assign in_ready = ctl.clr_done && (cnt_r != 2'(QDEPTH));
  assign push     = in_valid && in_ready;
  assign q_valid  = cnt_r != 2'd0;
  assign q_item   = q_mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (ctl.pop) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, ctl.pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wp_r] <= item;
    end
  end

endmodule
`default_nettype wire

@@ src/tcw_back.sv @@
// execution side: cursor update, cell writes, scroll copy, reads and result register
`default_nettype none
module tcw_back #(
  parameter int MAX_COLS = tcw_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS = tcw_pkg::MAX_ROWS_DEF,
  parameter int TAB_STEP = tcw_pkg::TAB_STEP_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire tcw_pkg::tcw_item_t         q_item,
  input  wire logic                       q_valid,
  output tcw_pkg::tcw_qctl_t              ctl,
  input  wire logic [tcw_pkg::COLS_W-1:0] cols_cfg,
  input  wire logic [tcw_pkg::ROWS_W-1:0] rows_cfg,
  input  wire logic                       follow_cfg,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [tcw_pkg::IDX_W-1:0]       out_cursor_pos,
  output logic [tcw_pkg::IDX_W-1:0]       out_shown_cursor,
  output logic                            out_scrolled,
  output logic [tcw_pkg::CELL_W-1:0]      out_cell_value
);
  import tcw_pkg::*;

  localparam int DEPTH  = MAX_COLS * MAX_ROWS;
  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int POS_RAW = $clog2(DEPTH + MAX_COLS + TAB_STEP) + 1;
  localparam int POS_W  = (POS_RAW > IDX_W) ? POS_RAW : IDX_W;

  localparam logic [2:0] ST_CLR   = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_RD    = 3'd2;
  localparam logic [2:0] ST_DIV   = 3'd3;
  localparam logic [2:0] ST_COPY  = 3'd4;
  localparam logic [2:0] ST_DRAIN = 3'd5;
  localparam logic [2:0] ST_FILL  = 3'd6;
  localparam logic [2:0] ST_DONE  = 3'd7;

  logic [2:0]        state_r, state_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [POS_W-1:0]  shown_r, shown_nxt;
  logic [POS_W-1:0]  cnt_r, cnt_nxt;
  logic              scr_r, scr_nxt;
  logic [CELL_W-1:0] cell_r, cell_nxt;
  logic              wr_item_r, wr_item_nxt;
  logic [AW-1:0]     cp_addr_r;
  logic              cp_vld_r;
  logic              out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]  out_pos_r;
  logic [IDX_W-1:0]  out_shown_r;
  logic              out_scr_r;
  logic [CELL_W-1:0] out_cell_r;
  logic              load_out;

  logic [COLS_W-1:0] eff_cols;
  logic [ROWS_W-1:0] eff_rows;
  logic [POS_W-1:0]  cols_w;
  logic [POS_W-1:0]  end_w;
  logic [POS_W-1:0]  top_w;
  logic [POS_W-1:0]  cand;
  logic [POS_W-1:0]  ridx_w;
  logic              pop;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [CHAR_W-1:0] ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [CHAR_W-1:0] ram_rdata;
  logic [POS_W-1:0]  copy_src;

  logic              div_start;
  logic              div_done;
  logic [COLS_W-1:0] div_rem;

  always_comb begin
    if (cols_cfg == '0) begin
      eff_cols = COLS_W'(1);
    end else if ({2'b0, cols_cfg} > 9'(MAX_COLS)) begin
      eff_cols = COLS_W'(MAX_COLS);
    end else begin
      eff_cols = cols_cfg;
    end
    if (rows_cfg == '0) begin
      eff_rows = ROWS_W'(1);
    end else if ({3'b0, rows_cfg} > 8'(MAX_ROWS)) begin
      eff_rows = ROWS_W'(MAX_ROWS);
    end else begin
      eff_rows = rows_cfg;
    end
  end

  assign cols_w   = POS_W'(eff_cols);
  assign end_w    = POS_W'({5'b0, eff_cols} * {7'b0, eff_rows});
  assign top_w    = end_w - cols_w;
  assign ridx_w   = POS_W'(q_item.ridx);
  assign copy_src = cnt_r + cols_w;
  assign pop      = (state_r == ST_IDLE) && q_valid;

  assign ctl.pop      = pop;
  assign ctl.clr_done = state_r != ST_CLR;

  always_comb begin
    cand = pos_r;
    case (state_r)
      ST_IDLE: begin
        case (q_item.op)
          OP_TAB:  cand = pos_r + POS_W'(TAB_STEP);
          OP_BKSP: cand = (pos_r == '0) ? pos_r : pos_r - 1'b1;
          OP_CHAR: cand = pos_r + 1'b1;
          default: cand = pos_r;
        endcase
      end
      ST_DIV:  cand = pos_r - POS_W'(div_rem) + cols_w;
      default: cand = pos_r;
    endcase
  end

  assign div_start = pop && (q_item.op == OP_NL);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cnt_r[AW-1:0];
    ram_wdata = CH_BLANK;
    ram_raddr = ridx_w[AW-1:0];
    case (state_r)
      ST_CLR: ram_we = 1'b1;
      ST_IDLE: begin
        ram_we    = pop && (q_item.op == OP_CHAR) && (pos_r < end_w);
        ram_waddr = pos_r[AW-1:0];
        ram_wdata = q_item.ch;
      end
      ST_COPY: begin
        ram_we    = cp_vld_r;
        ram_waddr = cp_addr_r;
        ram_wdata = ram_rdata;
        ram_raddr = copy_src[AW-1:0];
      end
      ST_DRAIN: begin
        ram_we    = 1'b1;
        ram_waddr = cp_addr_r;
        ram_wdata = ram_rdata;
      end
      ST_FILL: ram_we = 1'b1;
      default: ram_we = 1'b0;
    endcase
  end

  assign load_out = (state_r == ST_DONE) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    shown_nxt     = shown_r;
    cnt_nxt       = cnt_r;
    scr_nxt       = scr_r;
    cell_nxt      = cell_r;
    wr_item_nxt   = wr_item_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      ST_CLR: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == POS_W'(DEPTH - 1)) begin
          cnt_nxt   = '0;
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (pop) begin
          scr_nxt     = 1'b0;
          cell_nxt    = '0;
          wr_item_nxt = q_item.op != OP_READ;
          if (q_item.op == OP_READ) begin
            state_nxt = (ridx_w < POS_W'(DEPTH)) ? ST_RD : ST_DONE;
          end else if (q_item.op == OP_NL) begin
            state_nxt = ST_DIV;
          end else if (cand >= end_w) begin
            scr_nxt   = 1'b1;
            cnt_nxt   = (end_w > cols_w) ? '0 : top_w;
            state_nxt = (end_w > cols_w) ? ST_COPY : ST_FILL;
          end else begin
            pos_nxt   = cand;
            state_nxt = ST_DONE;
          end
        end
      end
      ST_RD: begin
        cell_nxt  = {ATTR_BYTE, ram_rdata};
        state_nxt = ST_DONE;
      end
      ST_DIV: begin
        if (div_done) begin
          if (cand >= end_w) begin
            scr_nxt   = 1'b1;
            cnt_nxt   = (end_w > cols_w) ? '0 : top_w;
            state_nxt = (end_w > cols_w) ? ST_COPY : ST_FILL;
          end else begin
            pos_nxt   = cand;
            state_nxt = ST_DONE;
          end
        end
      end
      ST_COPY: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == top_w - 1'b1) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        cnt_nxt   = top_w;
        state_nxt = ST_FILL;
      end
      ST_FILL: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == end_w - 1'b1) begin
          cnt_nxt   = '0;
          pos_nxt   = top_w;
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (load_out) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
          if (follow_cfg && wr_item_r) begin
            shown_nxt = pos_r;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      pos_r       <= '0;
      shown_r     <= '0;
      cnt_r       <= '0;
      cp_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      shown_r     <= shown_nxt;
      cnt_r       <= cnt_nxt;
      cp_vld_r    <= state_r == ST_COPY;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scr_r     <= scr_nxt;
    cell_r    <= cell_nxt;
    wr_item_r <= wr_item_nxt;
    cp_addr_r <= cnt_r[AW-1:0];
    if (load_out) begin
      out_pos_r   <= pos_r[IDX_W-1:0];
      out_shown_r <= shown_nxt[IDX_W-1:0];
      out_scr_r   <= scr_r;
      out_cell_r  <= cell_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_cursor_pos   = out_pos_r;
  assign out_shown_cursor = out_shown_r;
  assign out_scrolled     = out_scr_r;
  assign out_cell_value   = out_cell_r;

  tcw_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  tcw_div #(
    .POS_W (POS_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (pos_r),
    .divisor  (eff_cols),
    .done     (div_done),
    .rem      (div_rem)
  );

  a_wr_in_store: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (POS_W'(ram_waddr) < POS_W'(DEPTH)))
    else $error("cell write outside store");

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.pop |-> (state_r == ST_IDLE))
    else $error("queue pop outside idle");

  a_scroll_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && scr_r) |-> (pos_r == top_w))
    else $error("scroll left cursor off last row start");

  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FILL) |-> (cnt_r < end_w))
    else $error("blank fill past screen end");

  a_div_once: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |=> (state_r == ST_DIV))
    else $error("newline lost its remainder step");

endmodule
`default_nettype wire

@@ src/text_console_writer.sv @@
// text console writer top level: config registers, front end, back end
// printable, tab and backspace beats update the cursor, reads look up the store, a newline
// runs the divider (one remainder bit a cycle); a scroll adds a cell copy (none with one
// row) and a blank fill through the ram write port
// a 2-entry queue buffers input while the back end works through one beat at a time
// reset: synchronous, active low; a clearing pass then blanks every cell of the store
`default_nettype none
module text_console_writer #(
  parameter int MAX_COLS = tcw_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS = tcw_pkg::MAX_ROWS_DEF,
  parameter int TAB_STEP = tcw_pkg::TAB_STEP_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          in_kind,
  input  wire logic [tcw_pkg::CHAR_W-1:0]    in_char_code,
  input  wire logic [tcw_pkg::IDX_W-1:0]     in_read_index,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [tcw_pkg::IDX_W-1:0]          out_cursor_pos,
  output logic [tcw_pkg::IDX_W-1:0]          out_shown_cursor,
  output logic                               out_scrolled,
  output logic [tcw_pkg::CELL_W-1:0]         out_cell_value,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [tcw_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [tcw_pkg::CFG_DAT_W-1:0] cfg_data
);
  import tcw_pkg::*;

  logic [COLS_W-1:0] cols_r;
  logic [ROWS_W-1:0] rows_r;
  logic              follow_r;
  tcw_item_t         q_item;
  logic              q_valid;
  tcw_qctl_t         ctl;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r   <= COLS_RST;
      rows_r   <= ROWS_RST;
      follow_r <= FOLLOW_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_COLUMNS: cols_r   <= cfg_data[COLS_W-1:0];
        REG_ROWS:    rows_r   <= cfg_data[ROWS_W-1:0];
        REG_FOLLOW:  follow_r <= cfg_data[0];
        default:     cols_r   <= cols_r;
      endcase
    end
  end

  tcw_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_kind       (in_kind),
    .in_char_code  (in_char_code),
    .in_read_index (in_read_index),
    .ctl           (ctl),
    .q_item        (q_item),
    .q_valid       (q_valid)
  );

  tcw_back #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS),
    .TAB_STEP (TAB_STEP)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_item           (q_item),
    .q_valid          (q_valid),
    .ctl              (ctl),
    .cols_cfg         (cols_r),
    .rows_cfg         (rows_r),
    .follow_cfg       (follow_r),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_cursor_pos   (out_cursor_pos),
    .out_shown_cursor (out_shown_cursor),
    .out_scrolled     (out_scrolled),
    .out_cell_value   (out_cell_value)
  );

endmodule
`default_nettype wire
